// File: sv/hsv_pkg.sv
// Shared types, constants and sector codes for the HSV to RGB converter.
package hsv_pkg;

    // Field widths
    localparam int HueW   = 9;
    localparam int LevelW = 8;
    localparam int ProdW  = 2 * LevelW;

    // Arithmetic constants
    localparam int SectorDeg = 60;
    localparam int FracScale = 256;
    localparam int FullLevel = 255;
    localparam int HueMax    = (1 << HueW) - 1;
    localparam int MaxSector = HueMax / SectorDeg;
    localparam int SecW      = $clog2(MaxSector + 1);
    localparam int RemW      = $clog2(SectorDeg);

    // f = rem * 256 / 60 by reciprocal: rem * 17477 >> 12 is exact for rem < 60
    localparam int FracMul   = 17477;
    localparam int FracShift = 12;
    localparam int FracProdW = RemW + 15;

    // Sector routing codes; hue past 359 takes the last sector's routing
    localparam logic [2:0] SecRed     = 3'd0;
    localparam logic [2:0] SecYellow  = 3'd1;
    localparam logic [2:0] SecGreen   = 3'd2;
    localparam logic [2:0] SecCyan    = 3'd3;
    localparam logic [2:0] SecBlue    = 3'd4;
    localparam logic [2:0] SecMagenta = 3'd5;

    typedef logic [HueW-1:0]   t_hue;
    typedef logic [LevelW-1:0] t_level;
    typedef logic [ProdW-1:0]  t_prod;
    typedef logic [2:0]        t_sel;

    // Input item
    typedef struct packed {
        t_hue   hue;
        t_level saturation;
        t_level brightness;
    } t_pix;

    // After sector split
    typedef struct packed {
        t_sel   sel;
        t_level frac;
        t_level saturation;
        t_level brightness;
    } t_frac;

    // After the first multiply rank
    typedef struct packed {
        t_sel   sel;
        t_level brightness;
        t_level drop_q;
        t_level drop_t;
        t_prod  num_p;
    } t_drop;

    // After the second multiply rank
    typedef struct packed {
        t_sel   sel;
        t_level brightness;
        t_prod  num_p;
        t_prod  num_q;
        t_prod  num_t;
    } t_num;

    // Result item
    typedef struct packed {
        t_level red;
        t_level green;
        t_level blue;
    } t_rgb;

endpackage

// File: sv/hsv_if.sv
// Valid/ready channel interfaces for pixel input and RGB output items.
interface hsv_in_if;
    import hsv_pkg::*;
    logic   valid;
    logic   ready;
    t_hue   hue;
    t_level saturation;
    t_level brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_out_if;
    import hsv_pkg::*;
    logic   valid;
    logic   ready;
    t_level red;
    t_level green;
    t_level blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: sv/hsv_sector.sv
// Stage 1: hue sector, remainder and scaled in-sector fraction.
module hsv_sector
    import hsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_pix  i_pix,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_frac o_frac
);

    logic [SecW-1:0]      sec;
    t_hue                 base;
    logic [RemW-1:0]      rem;
    logic [FracProdW-1:0] frac_prod;
    t_frac                n_frac;
    t_frac                r_frac;
    logic                 r_vld;

    // Sector by threshold compares, remainder by one subtract
    always_comb begin
        sec = '0;
        for (int k = 1; k <= MaxSector; k++) begin
            if (i_pix.hue >= HueW'(k * SectorDeg)) begin
                sec = SecW'(k);
            end
        end
        base      = HueW'(sec * SectorDeg);
        rem       = RemW'(i_pix.hue - base);
        frac_prod = FracProdW'(rem) * FracProdW'(FracMul);

        n_frac.frac       = LevelW'(frac_prod >> FracShift);
        n_frac.saturation = i_pix.saturation;
        n_frac.brightness = i_pix.brightness;
        n_frac.sel        = (sec > SecW'(SecMagenta)) ? SecMagenta : 3'(sec);
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_frac <= n_frac;
        end
    end

    assign o_vld  = r_vld;
    assign o_frac = r_frac;

endmodule

// File: sv/hsv_drop.sv
// Stage 2: saturation products that set the q, t drops and the p numerator.
module hsv_drop
    import hsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_frac i_frac,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_drop o_drop
);

    t_prod prod_q;
    t_prod prod_t;
    t_drop n_drop;
    t_drop r_drop;
    logic  r_vld;

    // Three 8x8 multiplies side by side; /256 is a byte select
    always_comb begin
        prod_q = ProdW'(i_frac.saturation) * ProdW'(i_frac.frac);
        prod_t = ProdW'(i_frac.saturation)
               * ProdW'(LevelW'(FullLevel) - i_frac.frac);

        n_drop.sel        = i_frac.sel;
        n_drop.brightness = i_frac.brightness;
        n_drop.drop_q     = prod_q[ProdW-1:LevelW];
        n_drop.drop_t     = prod_t[ProdW-1:LevelW];
        n_drop.num_p      = ProdW'(i_frac.brightness)
                          * ProdW'(LevelW'(FullLevel) - i_frac.saturation);
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_drop <= n_drop;
        end
    end

    assign o_vld  = r_vld;
    assign o_drop = r_drop;

endmodule

// File: sv/hsv_scale.sv
// Stage 3: brightness products that give the q and t numerators.
module hsv_scale
    import hsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_drop i_drop,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_num  o_num
);

    t_num n_num;
    t_num r_num;
    logic r_vld;

    // v * (255 - drop) for q and t
    always_comb begin
        n_num.sel        = i_drop.sel;
        n_num.brightness = i_drop.brightness;
        n_num.num_p      = i_drop.num_p;
        n_num.num_q      = ProdW'(i_drop.brightness)
                         * ProdW'(LevelW'(FullLevel) - i_drop.drop_q);
        n_num.num_t      = ProdW'(i_drop.brightness)
                         * ProdW'(LevelW'(FullLevel) - i_drop.drop_t);
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_num <= n_num;
        end
    end

    assign o_vld = r_vld;
    assign o_num = r_num;

endmodule

// File: sv/hsv_route.sv
// Stage 4: divide the numerators by 255 and route levels by sector.
module hsv_route
    import hsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_num i_num,
    output logic o_vld,
    input  logic i_rdy,
    output t_rgb o_rgb
);

    // floor(x / 255) for x <= 65025, by (x + (x >> 8) + 1) >> 8
    function automatic t_level div_full(input t_prod x);
        logic [ProdW:0] acc;
        acc = (ProdW+1)'(x) + (ProdW+1)'(x >> LevelW) + (ProdW+1)'(1);
        return LevelW'(acc >> LevelW);
    endfunction

    t_level lvl_p;
    t_level lvl_q;
    t_level lvl_t;
    t_level v;
    t_rgb   n_rgb;
    t_rgb   r_rgb;
    logic   r_vld;

    // Zero saturation needs no special case: p, q and t all come out as v
    always_comb begin
        lvl_p = div_full(i_num.num_p);
        lvl_q = div_full(i_num.num_q);
        lvl_t = div_full(i_num.num_t);
        v     = i_num.brightness;
        unique case (i_num.sel)
            SecRed:    n_rgb = '{red: v,     green: lvl_t, blue: lvl_p};
            SecYellow: n_rgb = '{red: lvl_q, green: v,     blue: lvl_p};
            SecGreen:  n_rgb = '{red: lvl_p, green: v,     blue: lvl_t};
            SecCyan:   n_rgb = '{red: lvl_p, green: lvl_q, blue: v};
            SecBlue:   n_rgb = '{red: lvl_t, green: lvl_p, blue: v};
            default:   n_rgb = '{red: v,     green: lvl_p, blue: lvl_q};
        endcase
    end

    // Output register
    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_vld = r_vld;
    assign o_rgb = r_rgb;

endmodule

// File: sv/hsv_to_rgb_converter_core.sv
// Top level of the four-stage integer HSV to RGB pixel converter.
// Converts one pixel (hue in degrees, saturation, value) per clock into 8-bit
// red, green and blue. Each accepted input passes through four registered
// stages: sector split, saturation multiplies, brightness multiplies, then
// divide by 255 and sector routing. Each stage holds its own valid bit and is
// ready whenever it is empty or its successor is ready, so a stall at the
// output fills the stages one by one and nothing is dropped or repeated; with
// the output taken every cycle one item is accepted per cycle. Hue codes
// 360-511 use the magenta-to-red sector routing.
module hsv_to_rgb_converter_core
    import hsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsv_in_if.sink    i_pix,
    hsv_out_if.source o_rgb
);

    t_pix  pix;
    t_frac frac;
    t_drop drop;
    t_num  num;
    t_rgb  rgb;
    logic  vld_1, vld_2, vld_3;
    logic  rdy_2, rdy_3, rdy_4;

    assign pix = '{hue: i_pix.hue, saturation: i_pix.saturation,
                   brightness: i_pix.brightness};

    hsv_sector u_sector (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_pix.valid),
        .o_rdy  (i_pix.ready),
        .i_pix  (pix),
        .o_vld  (vld_1),
        .i_rdy  (rdy_2),
        .o_frac (frac)
    );

    hsv_drop u_drop (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (vld_1),
        .o_rdy  (rdy_2),
        .i_frac (frac),
        .o_vld  (vld_2),
        .i_rdy  (rdy_3),
        .o_drop (drop)
    );

    hsv_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (vld_2),
        .o_rdy  (rdy_3),
        .i_drop (drop),
        .o_vld  (vld_3),
        .i_rdy  (rdy_4),
        .o_num  (num)
    );

    hsv_route u_route (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (vld_3),
        .o_rdy  (rdy_4),
        .i_num  (num),
        .o_vld  (o_rgb.valid),
        .i_rdy  (o_rgb.ready),
        .o_rgb  (rgb)
    );

    assign o_rgb.red   = rgb.red;
    assign o_rgb.green = rgb.green;
    assign o_rgb.blue  = rgb.blue;

endmodule

// File: sim/tb.sv
// Testbench for the HSV to RGB pixel converter: directed, random and stall tests.
module tb;
    import hsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hsv_in_if  pix_if();
    hsv_out_if rgb_if();

    hsv_to_rgb_converter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_rgb   (rgb_if)
    );

    // RGB values still owed by the block, oldest first
    t_rgb rgb_pending[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_count    = 0;
    int pixels_sent   = 0;
    int rgb_checked   = 0;
    int grey_sent     = 0;
    int past_range    = 0;
    int error_count   = 0;

    always #1 i_clk = ~i_clk;

    // Integer HSV to RGB, truncating divisions throughout
    function automatic t_rgb rgb_from_hsv(t_pix px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned sector;
        int unsigned frac;
        int unsigned lvl_p;
        int unsigned lvl_q;
        int unsigned lvl_t;
        t_rgb        rgb;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        if (s == 0) begin
            rgb.red   = t_level'(v);
            rgb.green = t_level'(v);
            rgb.blue  = t_level'(v);
            return rgb;
        end
        sector = h / SectorDeg;
        frac   = (h % SectorDeg) * FracScale / SectorDeg;
        lvl_p  = v * (FullLevel - s) / FullLevel;
        lvl_q  = v * (FullLevel - s * frac / FracScale) / FullLevel;
        lvl_t  = v * (FullLevel - s * (FullLevel - frac) / FracScale) / FullLevel;
        // Route levels by sector; hue past 359 falls to magenta routing
        case (sector)
            SecRed: begin
                rgb = {t_level'(v), t_level'(lvl_t), t_level'(lvl_p)};
            end
            SecYellow: begin
                rgb = {t_level'(lvl_q), t_level'(v), t_level'(lvl_p)};
            end
            SecGreen: begin
                rgb = {t_level'(lvl_p), t_level'(v), t_level'(lvl_t)};
            end
            SecCyan: begin
                rgb = {t_level'(lvl_p), t_level'(lvl_q), t_level'(v)};
            end
            SecBlue: begin
                rgb = {t_level'(lvl_t), t_level'(lvl_p), t_level'(v)};
            end
            default: begin
                rgb = {t_level'(v), t_level'(lvl_p), t_level'(lvl_q)};
            end
        endcase
        return rgb;
    endfunction

    // Offer one pixel, idling at random first, and hold it until taken
    task automatic offer_pixel(input t_hue h, input t_level s, input t_level v);
        t_pix px;
        px = '{hue: h, saturation: s, brightness: v};
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.hue        <= h;
        pix_if.saturation <= s;
        pix_if.brightness <= v;
        do @(posedge i_clk); while (!pix_if.ready);
        rgb_pending.push_back(rgb_from_hsv(px));
        pixels_sent++;
        if (s == 0) grey_sent++;
        if (h >= 360) past_range++;
    endtask

    // Random pixel, weighted toward sector edges, out-of-range hue and extremes
    function automatic t_pix random_pixel();
        t_pix px;
        case ($urandom_range(9))
            0:       px.hue = t_hue'($urandom_range(360, HueMax));
            1:       px.hue = t_hue'($urandom_range(5) * SectorDeg + 59 * $urandom_range(1));
            2:       px.hue = t_hue'($urandom_range(HueMax));
            default: px.hue = t_hue'($urandom_range(359));
        endcase
        case ($urandom_range(9))
            0:       px.saturation = '0;
            1:       px.saturation = '1;
            default: px.saturation = t_level'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0:       px.brightness = '0;
            1:       px.brightness = '1;
            default: px.brightness = t_level'($urandom_range(255));
        endcase
        return px;
    endfunction

    // Output side: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            hold_count = hold_len;
            hold_len   = 0;
        end
        if (hold_count != 0) begin
            rgb_if.ready <= 1'b0;
            hold_count--;
        end else begin
            rgb_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each RGB item taken with the oldest pending one
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && rgb_if.valid && rgb_if.ready) begin
            if (rgb_pending.size() == 0) begin
                $display("%0t: unexpected RGB item r=%0d g=%0d b=%0d", $time,
                         rgb_if.red, rgb_if.green, rgb_if.blue);
                error_count++;
            end else begin
                want = rgb_pending.pop_front();
                rgb_checked++;
                if (rgb_if.red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.red, rgb_if.red);
                    error_count++;
                end
                if (rgb_if.green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.green, rgb_if.green);
                    error_count++;
                end
                if (rgb_if.blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.blue, rgb_if.blue);
                    error_count++;
                end
            end
        end
    end

    // Zero saturation gives grey at any hue
    task automatic test_grey();
        offer_pixel(9'd0, 8'd0, 8'd0);
        offer_pixel(9'd511, 8'd0, 8'd255);
        offer_pixel(9'd200, 8'd0, 8'd128);
        offer_pixel(9'd359, 8'd0, 8'd1);
    endtask

    // Every sector at its edges, full and minimal saturation and brightness
    task automatic test_sectors();
        offer_pixel(9'd0, 8'd255, 8'd255);
        offer_pixel(9'd30, 8'd255, 8'd255);
        offer_pixel(9'd59, 8'd255, 8'd255);
        offer_pixel(9'd60, 8'd255, 8'd255);
        offer_pixel(9'd119, 8'd1, 8'd255);
        offer_pixel(9'd120, 8'd255, 8'd255);
        offer_pixel(9'd180, 8'd128, 8'd200);
        offer_pixel(9'd240, 8'd255, 8'd255);
        offer_pixel(9'd299, 8'd170, 8'd85);
        offer_pixel(9'd300, 8'd255, 8'd255);
        offer_pixel(9'd359, 8'd255, 8'd255);
        offer_pixel(9'd0, 8'd1, 8'd1);
        offer_pixel(9'd359, 8'd255, 8'd0);
    endtask

    // Hue codes 360 and up keep the magenta routing
    task automatic test_hue_past_range();
        offer_pixel(9'd360, 8'd255, 8'd255);
        offer_pixel(9'd419, 8'd200, 8'd100);
        offer_pixel(9'd420, 8'd255, 8'd255);
        offer_pixel(9'd480, 8'd77, 8'd222);
        offer_pixel(9'd511, 8'd255, 8'd255);
    endtask

    // Random pixels under a given idle mix on each side
    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        t_pix px;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            px = random_pixel();
            offer_pixel(px.hue, px.saturation, px.brightness);
        end
    endtask

    // Long output hold while input keeps coming, so the pipe fills and stalls
    task automatic test_output_stall();
        t_pix px;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 60;
        repeat (30) begin
            px = random_pixel();
            offer_pixel(px.hue, px.saturation, px.brightness);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.hue        = '0;
        pix_if.saturation = '0;
        pix_if.brightness = '0;
        rgb_if.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grey();
        test_sectors();
        test_hue_past_range();
        test_random(11, 57, 340);
        test_random(57, 11, 340);
        test_output_stall();
        test_random(0, 0, 340);

        // Drain, then watch for any stray item
        pix_if.valid <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d pixels (%0d grey, %0d with hue past 359), checked %0d RGB items,",
                 pixels_sent, grey_sent, past_range, rgb_checked);
        $display("under input-heavy, output-heavy, no-idle and long output hold traffic.");
        if (error_count == 0) begin
            $display("hsv_to_rgb_converter_core verification clean");
        end else begin
            $display("hsv_to_rgb_converter_core verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("hsv_to_rgb_converter_core verification failed");
        $finish;
    end

endmodule

// File: files.f
sv/hsv_pkg.sv
sv/hsv_if.sv
sv/hsv_sector.sv
sv/hsv_drop.sv
sv/hsv_scale.sv
sv/hsv_route.sv
sv/hsv_to_rgb_converter_core.sv
sim/tb.sv
